// ----- sv/score_bucket_priority_queue_top_macros.svh -----
// Assertion macros for the score bucket priority queue.
// Used by the top level only; no other dependencies.
`ifndef SCORE_BUCKET_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SCORE_BUCKET_PRIORITY_QUEUE_TOP_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SBPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SBPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/sbpq_pkg.sv -----
// Shared types and codes for the score bucket priority queue.
// No dependencies.
package sbpq_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned PenW    = 6;

    typedef enum logic [1:0] {
        MODE_RESET = 2'd0,
        MODE_PUSH  = 2'd1,
        MODE_POP   = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_ENTRY    = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_SCORE    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MISMATCH   = 2'd0,
        CFG_GAP_OPEN   = 2'd1,
        CFG_GAP_EXTEND = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCESS,
        S_PUSH_WR,
        S_POP_WR,
        S_OUT
    } t_state;

    // record fields kept next to the interval payload
    typedef struct packed {
        logic        strand;
        logic [10:0] offset;
        logic [3:0]  mm;
        logic [3:0]  go;
        logic [3:0]  ge;
        logic [1:0]  edit;
        logic [10:0] ldo;
        logic [10:0] parent;
    } t_fields;

endpackage

// ----- sv/score_bucket_priority_queue_top.sv -----
// Score bucket priority queue: entry pool and score bins in on-chip memories.
// Depends on sbpq_pkg, sbpq_score and the assertion macro header.
//
// Usage: one transaction on the s_axis side carries a command (reset, push,
// pop best, read entry) and the candidate record; exactly one result
// transaction follows on m_axis. The user must write the penalty registers
// through the plain write port only while the block is idle; the block
// itself does not enforce this. Push and pop pass through the access,
// write-back and output states to the result register; reset and read skip
// the write-back state. One item is in flight at a time, because of the
// read-modify-write of the head and link memories with their registered
// reads; a new item is taken only after the last result has left.
// Reset clears the bin bitmap, the pool pointer and the queued count; memory
// contents stay undefined until written, with no clearing pass.
// When the receiver stalls, the result holds in the output register and no
// new item is taken until it leaves.
`include "score_bucket_priority_queue_top_macros.svh"
module score_bucket_priority_queue_top
    import sbpq_pkg::*;
#(
    parameter int unsigned POOL_DEPTH      = 1024,
    parameter int unsigned NUM_BINS        = 256,
    parameter int unsigned MAX_READ_LENGTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // mode[1:0], strand[2], read_offset[13:3], interval_low[45:14],
    // interval_high[77:46], mismatch_count[81:78], gap_open_count[85:82],
    // gap_extend_count[89:86], edit_state[91:90], is_difference[92],
    // ref_index[103:93], zero fill to 104
    input  logic [103:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // status[2:0], entry_index[12:3], out_strand[13], out_offset[24:14],
    // out_interval_low[56:25], out_interval_high[88:57], out_mismatches[92:89],
    // out_gap_opens[96:93], out_gap_extends[100:97], out_edit_state[102:101],
    // last_edit_offset[113:103], parent_index[124:114], zero fill to 128
    output logic [127:0]  m_axis_tdata,
    input  logic          i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [PenW-1:0]    i_cfg_data
);
    localparam int unsigned PW = $clog2(POOL_DEPTH);
    localparam int unsigned BW = $clog2(NUM_BINS);

    // memories
    logic [63:0]   mem_iv   [POOL_DEPTH];
    t_fields       mem_fld  [POOL_DEPTH];
    logic [PW-1:0] mem_link [POOL_DEPTH];
    logic [PW-1:0] mem_head [NUM_BINS];

    logic [NUM_BINS-1:0] r_nonempty;
    logic [PW:0]         r_wptr;
    logic [PW:0]         r_count;
    logic [PenW-1:0]     r_pen_mm, r_pen_go, r_pen_ge;

    t_state r_state, n_state;
    logic [103:0] r_in;
    logic [11:0]  score;
    logic [BW-1:0] r_bin;
    logic          r_bin_valid;
    logic [63:0]   rd_iv;
    t_fields       rd_fld;
    logic [PW-1:0] rd_link, rd_head;
    logic [127:0]  r_out;
    logic          r_out_valid;
    logic          fire_in;

    // input field views
    t_mode       in_mode;
    logic [10:0] in_off, in_ref;
    logic        ref_ok;
    logic [PW-1:0] ref_idx;
    assign in_mode = t_mode'(r_in[1:0]);
    assign in_off  = r_in[13:3];
    assign in_ref  = r_in[103:93];
    assign ref_ok  = !in_ref[10] && (32'(in_ref) < POOL_DEPTH);
    assign ref_idx = in_ref[PW-1:0];

    // score is captured with the accepted transaction, ready in the access state
    sbpq_score u_score (
        .i_clk(i_clk), .i_en(fire_in),
        .i_pen_mm(r_pen_mm), .i_pen_go(r_pen_go), .i_pen_ge(r_pen_ge),
        .i_mm(s_axis_tdata[81:78]), .i_go(s_axis_tdata[85:82]),
        .i_ge(s_axis_tdata[89:86]), .o_score(score)
    );

    // lowest nonempty bin, registered at entry to the access state
    logic [BW-1:0] n_bin;
    logic          n_bin_valid;
    always_comb begin
        n_bin = '0;
        n_bin_valid = 1'b0;
        for (int i = NUM_BINS - 1; i >= 0; i--) begin
            if (r_nonempty[i]) begin
                n_bin = BW'(i);
                n_bin_valid = 1'b1;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign fire_in = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (fire_in) n_state = S_ACCESS;
            S_ACCESS:  begin
                unique case (in_mode)
                    MODE_PUSH: n_state = S_PUSH_WR;
                    MODE_POP:  n_state = S_POP_WR;
                    default:   n_state = S_OUT;
                endcase
            end
            S_PUSH_WR: n_state = S_OUT;
            S_POP_WR:  n_state = S_OUT;
            S_OUT:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // memory reads: issued in S_ACCESS, data valid in the next state
    logic [PW-1:0] rd_addr;
    always_comb begin
        rd_addr = ref_idx;
        if (in_mode == MODE_POP) rd_addr = rd_head;
    end

    // head read happens in S_IDLE->S_ACCESS edge using the bitmap bin
    always_ff @(posedge i_clk) begin
        if (fire_in) rd_head <= mem_head[n_bin];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ACCESS) begin
            rd_iv   <= mem_iv[rd_addr];
            rd_fld  <= mem_fld[rd_addr];
            rd_link <= mem_link[rd_addr];
        end
    end

    // push bin head read for linking
    logic [PW-1:0] push_head;
    always_ff @(posedge i_clk) begin
        if (r_state == S_ACCESS) push_head <= mem_head[score[BW-1:0]];
    end

    // writes
    logic push_ok, full, score_bad;
    assign full      = (r_wptr == (PW+1)'(POOL_DEPTH));
    assign score_bad = (32'(score) >= NUM_BINS);
    assign push_ok   = !full && !score_bad;

    t_fields wr_fld;
    always_comb begin
        wr_fld.strand = r_in[2];
        wr_fld.offset = in_off;
        wr_fld.mm     = r_in[81:78];
        wr_fld.go     = r_in[85:82];
        wr_fld.ge     = r_in[89:86];
        wr_fld.edit   = r_in[91:90];
        if (ref_ok) begin
            wr_fld.ldo    = r_in[92] ? in_off : rd_fld.ldo;
            wr_fld.parent = in_ref;
        end else begin
            wr_fld.ldo    = in_off;
            wr_fld.parent = 11'h7FF;
        end
    end

    logic [PW-1:0] widx;
    logic [BW-1:0] sbin;
    assign widx = r_wptr[PW-1:0];
    assign sbin = score[BW-1:0];

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH_WR && push_ok) begin
            mem_iv[widx]   <= r_in[77:14];
            mem_fld[widx]  <= wr_fld;
            mem_link[widx] <= r_nonempty[sbin] ? push_head : widx;
            mem_head[sbin] <= widx;
        end else if (r_state == S_POP_WR && r_count != '0 && rd_link != rd_head) begin
            mem_head[r_bin] <= rd_link;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nonempty  <= '0;
            r_wptr      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pen_mm    <= PenW'(3);
            r_pen_go    <= PenW'(5);
            r_pen_ge    <= PenW'(2);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MISMATCH:   r_pen_mm <= i_cfg_data;
                    CFG_GAP_OPEN:   r_pen_go <= i_cfg_data;
                    CFG_GAP_EXTEND: r_pen_ge <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_ACCESS && in_mode == MODE_RESET) begin
                r_nonempty <= '0;
                r_wptr     <= '0;
                r_count    <= '0;
            end
            if (r_state == S_PUSH_WR && push_ok) begin
                r_nonempty[sbin] <= 1'b1;
                r_wptr  <= r_wptr + 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_POP_WR && r_count != '0 && r_bin_valid) begin
                if (rd_link == rd_head) r_nonempty[r_bin] <= 1'b0;
                r_count <= r_count - 1'b1;
            end
            if (r_state == S_OUT) r_out_valid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_in) begin
            r_in        <= s_axis_tdata;
            r_bin       <= n_bin;
            r_bin_valid <= n_bin_valid;
        end
    end

    // result assembly
    function automatic logic [127:0] pack_entry(t_status st, logic [PW-1:0] idx,
                                                logic [63:0] iv, t_fields f);
        logic [127:0] v;
        v = '0;
        v[2:0]     = st;
        v[12:3]    = 10'(idx);
        v[13]      = f.strand;
        v[24:14]   = f.offset;
        v[88:25]   = iv;
        v[92:89]   = f.mm;
        v[96:93]   = f.go;
        v[100:97]  = f.ge;
        v[102:101] = f.edit;
        v[113:103] = f.ldo;
        v[124:114] = f.parent;
        return v;
    endfunction

    logic [127:0] r_res;
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH_WR) begin
            if (full)           r_res <= {125'd0, ST_FULL};
            else if (score_bad) r_res <= {125'd0, ST_SCORE};
            else                r_res <= {115'd0, 10'(widx), ST_DONE};
        end else if (r_state == S_POP_WR) begin
            if (r_count == '0 || !r_bin_valid)
                r_res <= {125'd0, ST_EMPTY};
            else
                r_res <= pack_entry(ST_ENTRY, rd_head, rd_iv, rd_fld);
        end else if (r_state == S_ACCESS) begin
            r_res <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            if (in_mode == MODE_READ && ref_ok)
                r_out <= pack_entry(ST_ENTRY, ref_idx, rd_iv, rd_fld);
            else
                r_out <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    `SBPQ_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready)
    `SBPQ_ASSERT_IMP(a_count_le_wptr, i_clk, i_rst_n, 1'b1, r_count <= r_wptr)
    `SBPQ_ASSERT_NEXT(a_out_follows, i_clk, i_rst_n, r_state == S_OUT, m_axis_tvalid)
    `SBPQ_ASSERT_IMP(a_empty_bitmap, i_clk, i_rst_n, r_count == '0, r_nonempty == '0)
endmodule

// ----- sv/sbpq_score.sv -----
// Registered score computation for a pushed candidate.
// Depends on sbpq_pkg.
module sbpq_score
    import sbpq_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [PenW-1:0] i_pen_mm,
    input  logic [PenW-1:0] i_pen_go,
    input  logic [PenW-1:0] i_pen_ge,
    input  logic [3:0]      i_mm,
    input  logic [3:0]      i_go,
    input  logic [3:0]      i_ge,
    output logic [11:0]     o_score
);
    logic [11:0] n_score;
    logic [6:0]  open_pen;

    always_comb begin
        open_pen = {1'b0, i_pen_go} + {1'b0, i_pen_ge};
        n_score  = 12'(i_mm) * 12'(i_pen_mm) + 12'(i_go) * 12'(open_pen)
                 + 12'(i_ge) * 12'(i_pen_ge);
    end

    // capture with the accepted transaction and hold until the next one
    always_ff @(posedge i_clk) begin
        if (i_en) o_score <= n_score;
    end
endmodule
